// ===== sv/rth_pkg.sv =====
package rth_pkg;

	localparam int STAGES = 16;
	// vector width: |x| up to 510*2^16 ~ 2^25, growth ~1.65 -> 28 bits; keep margin
	localparam int VW = 30;
	localparam int AW = 17;
	localparam int SQRT3_Q16 = 113512;
	localparam int QW = 10;  // sum width
	localparam int NW = 18;  // numerator 255*(sum-3min) < 2^18

	typedef struct packed {
		logic gray;
		logic [7:0] inten;
		logic [QW-1:0] den;
	} side_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic [AW-1:0] acc;
		logic [7:0] sat;
		logic [NW-1:0] rem;
		side_t side;
	} cell_t;

	function automatic logic [AW-1:0] atan_turns(input logic [3:0] i);
		logic [AW-1:0] t;
		unique case (i)
			4'd0: t = 17'd8192;
			4'd1: t = 17'd4836;
			4'd2: t = 17'd2555;
			4'd3: t = 17'd1297;
			4'd4: t = 17'd651;
			4'd5: t = 17'd326;
			4'd6: t = 17'd163;
			4'd7: t = 17'd81;
			4'd8: t = 17'd41;
			4'd9: t = 17'd20;
			4'd10: t = 17'd10;
			4'd11: t = 17'd5;
			4'd12: t = 17'd3;
			4'd13: t = 17'd1;
			4'd14: t = 17'd1;
			default: t = 17'd0;
		endcase
		return t;
	endfunction

endpackage

// ===== sv/rth_if.sv =====
interface rth_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rth_cell.sv =====
// One CORDIC rotation plus, in the first eight cells, one bit of the
// restoring saturation divide (quotient is at most 255, eight bits).
module rth_cell (
	input  logic clk,
	input  logic en,
	input  logic [3:0] idx,
	input  rth_pkg::cell_t d,
	output rth_pkg::cell_t q
);
	import rth_pkg::*;

	cell_t n;
	logic [NW:0] trial;
	logic [2:0] bitpos;

	always_comb begin
		n = d;
		if (d.y > 0) begin
			n.x = d.x + (d.y >>> idx);
			n.y = d.y - (d.x >>> idx);
			n.acc = d.acc + atan_turns(idx);
		end else begin
			n.x = d.x - (d.y >>> idx);
			n.y = d.y + (d.x >>> idx);
			n.acc = d.acc - atan_turns(idx);
		end
		bitpos = 3'd7 - idx[2:0];
		trial = {1'b0, d.rem} - ({{(NW+1-QW){1'b0}}, d.side.den} << bitpos);
		if (idx < 4'd8 && !trial[NW]) begin
			n.rem = trial[NW-1:0];
			n.sat[bitpos] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= n;
	end
endmodule

// ===== sv/rgb_to_hsi_pixel.sv =====
// Channel | dir | payload
// pix     | in  | red[7:0] green[7:0] blue[7:0]
// hsi     | out | hue[7:0] saturation[7:0] intensity[7:0]
// One pixel per clock while the chain is not stalled; the result passes through
// one setup register, 16 CORDIC cells, one output register.
// Saturation divide is folded into the first cells.
// Reset clears only the valid chain. The whole chain stalls together when
// the output is full and not taken.
module rgb_to_hsi_pixel (
	input  logic clk,
	input  logic arst_n,
	rth_if.sink   pix,
	rth_if.source hsi
);
	import rth_pkg::*;

	localparam int D = STAGES + 1;
	logic [D:0] vld_q;
	logic adv;
	cell_t c [0:STAGES];
	logic [7:0] b, g, r;
	logic [QW-1:0] sum;
	logic [7:0] mn;
	logic signed [VW-1:0] x0, y0;
	logic [7:0] hue_q, sat_q, int_q;
	logic [AW-1:0] hr;

	assign adv = !vld_q[D] || hsi.ready;
	assign pix.ready = adv;
	assign {r, g, b} = pix.data;

	always_comb begin
		sum = QW'(r) + QW'(g) + QW'(b);
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		x0 = VW'((($signed({2'b0, r}) <<< 1) - $signed({2'b0, g}) - $signed({2'b0, b}))) <<< 16;
		y0 = VW'($signed({1'b0, g}) - $signed({1'b0, b})) * VW'(SQRT3_Q16);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c[0].side.gray <= (r == g) && (g == b);
			// floor(sum/3) by reciprocal multiply, exact for sum below 2048
			c[0].side.inten <= 8'((20'(sum) * 20'd683) >> 11);
			c[0].side.den <= sum;
			c[0].rem <= NW'(18'(sum - 10'(3 * mn)) * 18'd255);
			c[0].sat <= 8'd0;
			c[0].x <= (x0 < 0) ? -x0 : x0;
			c[0].y <= (x0 < 0) ? -y0 : y0;
			c[0].acc <= (x0 < 0) ? AW'(32768) : '0;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		rth_cell u_cell (.clk(clk), .en(adv), .idx(4'(i)), .d(c[i]), .q(c[i+1]));
	end

	assign hr = c[STAGES].acc + AW'(128);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[D-1:0], pix.valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_q <= c[STAGES].side.gray ? 8'd0 : hr[15:8];
			sat_q <= (c[STAGES].side.den == '0) ? 8'd0 : c[STAGES].sat;
			int_q <= c[STAGES].side.inten;
		end
	end

	assign hsi.valid = vld_q[D];
	assign hsi.data = {hue_q, sat_q, int_q};
endmodule

// ===== tb/sv/tb_rgb_to_hsi_pixel.sv =====
module tb_rgb_to_hsi_pixel;
	timeunit 1ns;
	timeprecision 1ps;

	import rth_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_PIXELS = 1500;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] intensity;
	} hsi_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rth_if #(.W(24)) pix ();
	rth_if #(.W(24)) hsi ();

	rgb_to_hsi_pixel uut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.hsi(hsi)
	);

	always #5 clk = ~clk;

	pixel_t pending_pixels[$];
	hsi_t expected_hsi[$];
	bit failed = 1'b0;
	int idle_cycles = 0;

	// CORDIC vectoring on the chromaticity plane, angle in 1/65536 turns
	function automatic logic [7:0] hue_angle(int r, int g, int b);
		longint x, y, nx, ny;
		logic [31:0] acc;
		int arctan[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
			41, 20, 10, 5, 3, 1, 1, 0};
		if (r == g && g == b)
			return 8'd0;
		x = longint'(2 * r - g - b) * 65536;
		y = longint'(g - b) * SQRT3_Q16;
		acc = 32'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = 32'd32768;
		end
		for (int i = 0; i < 16; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				acc = acc + arctan[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				acc = acc - arctan[i];
			end
			x = nx;
			y = ny;
		end
		acc = acc + 32'd128;
		return acc[15:8];
	endfunction

	function automatic hsi_t convert_pixel(pixel_t p);
		hsi_t h;
		int sum, mn;
		sum = p.red + p.green + p.blue;
		mn = p.red;
		if (p.green < mn) mn = p.green;
		if (p.blue < mn) mn = p.blue;
		h.hue = hue_angle(p.red, p.green, p.blue);
		h.saturation = (sum == 0) ? 8'd0 : 8'((255 * (sum - 3 * mn)) / sum);
		h.intensity = 8'(sum / 3);
		return h;
	endfunction

	function automatic pixel_t rgb(int r, int g, int b);
		pixel_t p;
		p.red = 8'(r);
		p.green = 8'(g);
		p.blue = 8'(b);
		return p;
	endfunction

	// sender: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.data <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!pix.valid || pix.ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				pix.valid <= 1'b0;
			end else if (pending_pixels.size() > 0) begin
				pixel_t p;
				p = pending_pixels.pop_front();
				expected_hsi.push_back(convert_pixel(p));
				pix.valid <= 1'b1;
				pix.data <= p;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	// receiver: ready follows a stall mode that is redrawn at random periodically
	int stall_phase = 0;
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsi.ready <= 1'b0;
			stall_phase <= 0;
			stall_mode <= 0;
		end else begin
			stall_phase <= stall_phase + 1;
			if (stall_phase % 64 == 63)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: hsi.ready <= 1'b1;
				1: hsi.ready <= $urandom_range(0, 1);
				2: hsi.ready <= ($urandom_range(0, 7) == 0);
				default: hsi.ready <= (stall_phase % 5 != 0);
			endcase
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix.valid && pix.ready) || (hsi.valid && hsi.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (hsi.valid && hsi.ready) begin
				hsi_t got, want;
				got = hsi.data;
				if (expected_hsi.size() == 0) begin
					$display("%0t: unexpected result hue=%0d sat=%0d int=%0d", $time,
						got.hue, got.saturation, got.intensity);
					failed = 1'b1;
				end else begin
					want = expected_hsi.pop_front();
					if (got.hue !== want.hue) begin
						$display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
						failed = 1'b1;
					end
					if (got.saturation !== want.saturation) begin
						$display("%0t: saturation expected %0d actual %0d", $time,
							want.saturation, got.saturation);
						failed = 1'b1;
					end
					if (got.intensity !== want.intensity) begin
						$display("%0t: intensity expected %0d actual %0d", $time,
							want.intensity, got.intensity);
						failed = 1'b1;
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int r, g, b, base;
		pix.valid = 1'b0;
		pix.data = '0;
		hsi.ready = 1'b0;

		// black, white, grays, primaries, secondaries, blue above green
		pending_pixels.push_back(rgb(0, 0, 0));
		pending_pixels.push_back(rgb(255, 255, 255));
		pending_pixels.push_back(rgb(128, 128, 128));
		pending_pixels.push_back(rgb(1, 1, 1));
		pending_pixels.push_back(rgb(255, 0, 0));
		pending_pixels.push_back(rgb(0, 255, 0));
		pending_pixels.push_back(rgb(0, 0, 255));
		pending_pixels.push_back(rgb(255, 255, 0));
		pending_pixels.push_back(rgb(0, 255, 255));
		pending_pixels.push_back(rgb(255, 0, 255));
		pending_pixels.push_back(rgb(1, 0, 0));
		pending_pixels.push_back(rgb(0, 1, 0));
		pending_pixels.push_back(rgb(0, 0, 1));
		pending_pixels.push_back(rgb(255, 254, 254));
		pending_pixels.push_back(rgb(254, 255, 255));
		pending_pixels.push_back(rgb(0, 255, 254));
		pending_pixels.push_back(rgb(0, 254, 255));
		pending_pixels.push_back(rgb(255, 128, 0));
		pending_pixels.push_back(rgb(255, 0, 128));
		pending_pixels.push_back(rgb(100, 200, 50));
		pending_pixels.push_back(rgb(50, 60, 200));
		pending_pixels.push_back(rgb(170, 85, 85));
		pending_pixels.push_back(rgb(255, 1, 255));

		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					r = $urandom_range(0, 255);
					g = $urandom_range(0, 255);
					b = $urandom_range(0, 255);
				end
				2: begin
					// near gray: tiny vectors stress the small-angle stages
					base = $urandom_range(0, 255);
					r = base + $urandom_range(0, 4) - 2;
					g = base + $urandom_range(0, 4) - 2;
					b = base + $urandom_range(0, 4) - 2;
					if (r < 0) r = 0; if (r > 255) r = 255;
					if (g < 0) g = 0; if (g > 255) g = 255;
					if (b < 0) b = 0; if (b > 255) b = 255;
				end
				default: begin
					// red pinned to an extreme, blue equal to green or drawn at random
					r = $urandom_range(0, 1) * 255;
					g = $urandom_range(0, 255);
					b = ($urandom_range(0, 1) == 0) ? g : $urandom_range(0, 255);
				end
			endcase
			pending_pixels.push_back(rgb(r, g, b));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_pixels.size() > 0 || expected_hsi.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (!failed && expected_hsi.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== rgb_to_hsi_pixel.f =====
sv/rth_pkg.sv
sv/rth_if.sv
sv/rth_cell.sv
sv/rgb_to_hsi_pixel.sv
tb/sv/tb_rgb_to_hsi_pixel.sv
